FILE: src/sti_pkg.sv
// Shared types and constants of the sound timer and interrupt register block.
package sti_pkg;

  // Divider limit and count width.
  localparam int DivW = 23;

  // Item commands.
  typedef enum logic [2:0] {
    CMD_READ        = 3'd0,
    CMD_WRITE       = 3'd1,
    CMD_TICK        = 3'd2,
    CMD_LOAD_SERIN  = 3'd3,
    CMD_LOAD_SEROUT = 3'd4
  } sti_cmd_e;

  // Register offsets.
  localparam logic [3:0] OFF_FREQ1    = 4'd0;
  localparam logic [3:0] OFF_FREQ2    = 4'd2;
  localparam logic [3:0] OFF_FREQ3    = 4'd4;
  localparam logic [3:0] OFF_FREQ4    = 4'd6;
  localparam logic [3:0] OFF_POT_LAST = 4'd7;
  localparam logic [3:0] OFF_AUDCTL   = 4'd8;
  localparam logic [3:0] OFF_KBCODE   = 4'd9;
  localparam logic [3:0] OFF_RANDOM   = 4'd10;
  localparam logic [3:0] OFF_SERIO    = 4'd13;
  localparam logic [3:0] OFF_IRQ      = 4'd14;
  localparam logic [3:0] OFF_SKCTL    = 4'd15;

  // Audio control bits.
  localparam int AC_FAST_BASE = 0;
  localparam int AC_CH34_JOIN = 3;
  localparam int AC_CH12_JOIN = 4;
  localparam int AC_CH3_FAST  = 5;
  localparam int AC_CH1_FAST  = 6;

  // Interrupt bits, same position in the raised vector and in the status byte.
  localparam int IRQ_T1     = 0;
  localparam int IRQ_T2     = 1;
  localparam int IRQ_T4     = 2;
  localparam int IRQ_XMT    = 3;
  localparam int IRQ_SEROUT = 4;
  localparam int IRQ_SERIN  = 5;
  localparam int IrqW       = 6;

  // Serial status bits cleared by the keyboard.
  localparam int SKSTAT_KEY   = 2;
  localparam int SKSTAT_SHIFT = 3;

  // Conditions under which a serial-out write reaches the link.
  localparam logic [7:0] SKCTL_MODE_MASK   = 8'h70;
  localparam logic [7:0] SKCTL_MODE_SEROUT = 8'h20;
  localparam logic [7:0] FREQ3_SEROUT      = 8'h28;
  localparam logic [7:0] AUDCTL_SEROUT     = 8'h28;

  typedef struct packed {
    logic load;
    logic tick;
  } sti_div_ctrl_t;

  typedef struct packed {
    logic load_serin;
    logic load_serout;
    logic tick;
  } sti_ser_ctrl_t;

endpackage

FILE: src/sound_timer_irq_registers.sv
// Top level: sound-chip timer, interrupt and serial control register set.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i, in_ready_o | command, reg_offset, write_data,
//          |                        | external_data, key_code, shift_held,
//          |                        | key_pressed, delay_value
//  out     | out_valid_o,out_ready_i| read_data, irq_raised, irq_status_now,
//          |                        | serial_out_valid, serial_out_byte,
//          |                        | serial_in_taken
//
// One item per cycle sustained while the output takes results; the input
// register captures an item at its transfer and the result register takes
// its result once the output slot is free. The whole update of one item,
// including the divider limit multiply, runs between those registers.
// Reset clears the control and state registers to their power-on values; the
// interrupt status returns to all inactive. A stalled output holds the result
// register and the input register, and in_ready_o drops only when both are full.
module sound_timer_irq_registers import sti_pkg::*; #(
  parameter int unsigned SCANLINE_CYCLES  = 114,
  parameter int unsigned SLOW_BASE_CYCLES = 28,
  parameter int unsigned XMTDONE_DELAY    = 15
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      command_i,
  input  logic [3:0]      reg_offset_i,
  input  logic [7:0]      write_data_i,
  input  logic [7:0]      external_data_i,
  input  logic [7:0]      key_code_i,
  input  logic            shift_held_i,
  input  logic            key_pressed_i,
  input  logic [15:0]     delay_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      read_data_o,
  output logic [IrqW-1:0] irq_raised_o,
  output logic [7:0]      irq_status_now_o,
  output logic            serial_out_valid_o,
  output logic [7:0]      serial_out_byte_o,
  output logic            serial_in_taken_o
);

  localparam int unsigned BaseMax = (SCANLINE_CYCLES > SLOW_BASE_CYCLES) ?
                                    SCANLINE_CYCLES : SLOW_BASE_CYCLES;
  localparam int BaseW = $clog2(BaseMax + 1);
  localparam int ProdW = (17 + BaseW > DivW) ? 17 + BaseW : DivW;

  // Scale a divide count by the base clock; keep the low divider bits.
  function automatic logic [DivW-1:0] scale(input logic [16:0] n,
                                            input logic [BaseW-1:0] b);
    logic [ProdW-1:0] p;
    p = ProdW'(n) * ProdW'(b);
    return p[DivW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic        stg_valid_q;
  logic [2:0]  cmd_q;
  logic [3:0]  off_q;
  logic [7:0]  wdata_q;
  logic [7:0]  ext_q;
  logic [7:0]  key_q;
  logic        shift_q;
  logic        press_q;
  logic [15:0] delay_q;
  logic        in_xfer;
  logic        advance;

  // Move the held item into the result register whenever that slot frees up.
  assign advance    = stg_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= command_i;
      off_q   <= reg_offset_i;
      wdata_q <= write_data_i;
      ext_q   <= external_data_i;
      key_q   <= key_code_i;
      shift_q <= shift_held_i;
      press_q <= key_pressed_i;
      delay_q <= delay_value_i;
    end
  end

  // ---------------------------------------------------------------------
  // Register set
  // ---------------------------------------------------------------------
  logic [7:0] freq_q [4];
  logic [7:0] freq_d [4];
  logic [7:0] audctl_q, audctl_d;
  logic [7:0] irq_en_q, irq_en_d;
  logic [7:0] irq_st_q, irq_st_d;
  logic [7:0] skctl_q, skctl_d;

  logic [BaseW-1:0] base;
  logic [15:0]      pair12, pair34;
  logic [DivW-1:0]  lim1, lim2, lim4;

  sti_div_ctrl_t div_ctrl [3];   // channels 1, 2 and 4
  logic [2:0]    div_fire;
  sti_ser_ctrl_t ser_ctrl;
  logic [2:0]    ser_fire;

  logic [7:0]      rd;
  logic [IrqW-1:0] raised;
  logic            so_valid;
  logic [7:0]      so_byte;
  logic            si_taken;
  logic            is_tick;

  assign is_tick = advance && (cmd_q == CMD_TICK);

  // Limits follow the register values after this item's write.
  assign base   = audctl_d[AC_FAST_BASE] ? BaseW'(SCANLINE_CYCLES)
                                         : BaseW'(SLOW_BASE_CYCLES);
  assign pair12 = {freq_d[1], freq_d[0]};
  assign pair34 = {freq_d[3], freq_d[2]};

  always_comb begin
    lim1 = audctl_d[AC_CH1_FAST] ? DivW'(17'(freq_d[0]) + 17'd4)
                                 : scale(17'(freq_d[0]) + 17'd1, base);
    if (audctl_d[AC_CH12_JOIN]) begin
      lim2 = audctl_d[AC_CH1_FAST] ? DivW'(17'(pair12) + 17'd7)
                                   : scale(17'(pair12) + 17'd1, base);
    end else begin
      lim2 = scale(17'(freq_d[1]) + 17'd1, base);
    end
    if (audctl_d[AC_CH34_JOIN]) begin
      lim4 = audctl_d[AC_CH3_FAST] ? DivW'(17'(pair34) + 17'd7)
                                   : scale(17'(pair34) + 17'd1, base);
    end else begin
      lim4 = scale(17'(freq_d[3]) + 17'd1, base);
    end
  end

  always_comb begin
    freq_d   = freq_q;
    audctl_d = audctl_q;
    irq_en_d = irq_en_q;
    irq_st_d = irq_st_q;
    skctl_d  = skctl_q;
    rd       = '0;
    raised   = '0;
    so_valid = 1'b0;
    so_byte  = '0;
    si_taken = 1'b0;
    for (int i = 0; i < 3; i++) begin
      div_ctrl[i].load = 1'b0;
      div_ctrl[i].tick = is_tick;
    end
    ser_ctrl.tick        = is_tick;
    ser_ctrl.load_serin  = advance && (cmd_q == CMD_LOAD_SERIN);
    ser_ctrl.load_serout = advance && (cmd_q == CMD_LOAD_SEROUT);

    if (advance) begin
      case (cmd_q)
        CMD_READ: begin
          if (off_q inside {[4'd0:OFF_POT_LAST], OFF_RANDOM}) begin
            rd = ext_q;
          end else if (off_q == OFF_KBCODE) begin
            rd = key_q;
          end else if (off_q == OFF_SERIO) begin
            rd       = ext_q;
            si_taken = 1'b1;
          end else if (off_q == OFF_IRQ) begin
            rd = irq_st_q;
          end else if (off_q == OFF_SKCTL) begin
            rd               = 8'hFF;
            rd[SKSTAT_SHIFT] = !shift_q;
            rd[SKSTAT_KEY]   = !press_q;
          end
        end
        CMD_WRITE: begin
          case (off_q)
            OFF_FREQ1: begin
              freq_d[0]        = wdata_q;
              div_ctrl[0].load = 1'b1;
              div_ctrl[1].load = audctl_q[AC_CH12_JOIN];
            end
            OFF_FREQ2: begin
              freq_d[1]        = wdata_q;
              div_ctrl[1].load = 1'b1;
            end
            OFF_FREQ3: begin
              // channel 3 raises no interrupt; only the joined pair matters
              freq_d[2]        = wdata_q;
              div_ctrl[2].load = audctl_q[AC_CH34_JOIN];
            end
            OFF_FREQ4: begin
              freq_d[3]        = wdata_q;
              div_ctrl[2].load = 1'b1;
            end
            OFF_AUDCTL: begin
              audctl_d = wdata_q;
              for (int i = 0; i < 3; i++) begin
                div_ctrl[i].load = 1'b1;
              end
            end
            OFF_SERIO: begin
              if (((skctl_q & SKCTL_MODE_MASK) == SKCTL_MODE_SEROUT) &&
                  (freq_q[2] == FREQ3_SEROUT) && (freq_q[3] == '0) &&
                  ((audctl_q & AUDCTL_SEROUT) == AUDCTL_SEROUT)) begin
                so_valid = 1'b1;
                so_byte  = wdata_q;
              end
            end
            OFF_IRQ: begin
              // disabled sources drop back to inactive
              irq_en_d = wdata_q;
              irq_st_d = irq_st_q | ~wdata_q;
            end
            OFF_SKCTL: begin
              skctl_d = wdata_q;
            end
            default: begin
            end
          endcase
        end
        CMD_TICK: begin
          // Serial sources clear status even when disabled.
          if (ser_fire[0]) begin
            irq_st_d[IRQ_SERIN] = 1'b0;
            raised[IRQ_SERIN]   = irq_en_q[IRQ_SERIN];
          end
          if (ser_fire[1]) begin
            irq_st_d[IRQ_SEROUT] = 1'b0;
            raised[IRQ_SEROUT]   = irq_en_q[IRQ_SEROUT];
          end
          if (ser_fire[2]) begin
            irq_st_d[IRQ_XMT] = 1'b0;
            raised[IRQ_XMT]   = irq_en_q[IRQ_XMT];
          end
          // Timer sources act only when enabled.
          if (div_fire[0] && irq_en_q[IRQ_T1]) begin
            irq_st_d[IRQ_T1] = 1'b0;
            raised[IRQ_T1]   = 1'b1;
          end
          if (div_fire[1] && irq_en_q[IRQ_T2]) begin
            irq_st_d[IRQ_T2] = 1'b0;
            raised[IRQ_T2]   = 1'b1;
          end
          if (div_fire[2] && irq_en_q[IRQ_T4]) begin
            irq_st_d[IRQ_T4] = 1'b0;
            raised[IRQ_T4]   = 1'b1;
          end
        end
        default: begin
          // delay loads go to the serial unit; unknown commands do nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        freq_q[i] <= '0;
      end
      audctl_q <= '0;
      irq_en_q <= '0;
      irq_st_q <= 8'hFF;
      skctl_q  <= '0;
    end else begin
      freq_q   <= freq_d;
      audctl_q <= audctl_d;
      irq_en_q <= irq_en_d;
      irq_st_q <= irq_st_d;
      skctl_q  <= skctl_d;
    end
  end

  // ---------------------------------------------------------------------
  // Timer dividers for the interrupting channels 1, 2 and 4
  // ---------------------------------------------------------------------
  sti_divider #(.SCANLINE_CYCLES(SCANLINE_CYCLES)) u_div1 (
    .clk_i, .rst_ni, .ctrl_i(div_ctrl[0]), .limit_i(lim1), .fire_o(div_fire[0])
  );
  sti_divider #(.SCANLINE_CYCLES(SCANLINE_CYCLES)) u_div2 (
    .clk_i, .rst_ni, .ctrl_i(div_ctrl[1]), .limit_i(lim2), .fire_o(div_fire[1])
  );
  sti_divider #(.SCANLINE_CYCLES(SCANLINE_CYCLES)) u_div4 (
    .clk_i, .rst_ni, .ctrl_i(div_ctrl[2]), .limit_i(lim4), .fire_o(div_fire[2])
  );

  // ---------------------------------------------------------------------
  // Serial interrupt delays
  // ---------------------------------------------------------------------
  sti_serial #(.XMTDONE_DELAY(XMTDONE_DELAY)) u_serial (
    .clk_i, .rst_ni, .ctrl_i(ser_ctrl), .delay_i(delay_q), .fire_o(ser_fire)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      read_data_o        <= rd;
      irq_raised_o       <= raised;
      irq_status_now_o   <= irq_st_d;
      serial_out_valid_o <= so_valid;
      serial_out_byte_o  <= so_byte;
      serial_in_taken_o  <= si_taken;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/sti_divider.sv
// One timer divider channel: limit, cycle count and wrap detection per tick.
module sti_divider import sti_pkg::*; #(
  parameter int unsigned SCANLINE_CYCLES = 114
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sti_div_ctrl_t   ctrl_i,
  input  logic [DivW-1:0] limit_i,
  output logic            fire_o
);

  localparam int ScanW = $clog2(SCANLINE_CYCLES + 1);
  localparam int SumW  = ((ScanW > DivW) ? ScanW : DivW) + 1;

  logic [DivW-1:0] limit_q, limit_d;
  logic [DivW-1:0] count_q, count_d;
  logic [SumW-1:0] sum;
  logic            wrap;

  assign sum    = SumW'(count_q) + SumW'(SCANLINE_CYCLES);
  assign wrap   = sum > SumW'(limit_q);
  assign fire_o = ctrl_i.tick && wrap;

  always_comb begin
    limit_d = limit_q;
    count_d = count_q;
    if (ctrl_i.load && (limit_i != limit_q)) begin
      // a new limit restarts the count
      limit_d = limit_i;
      count_d = '0;
    end else if (ctrl_i.tick) begin
      count_d = wrap ? '0 : sum[DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      count_q <= '0;
    end else begin
      limit_q <= limit_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: src/sti_serial.sv
// Serial interrupt delays: serial-in, serial-out and chained transmit-done.
module sti_serial import sti_pkg::*; #(
  parameter int unsigned XMTDONE_DELAY = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sti_ser_ctrl_t ctrl_i,
  input  logic [15:0]   delay_i,
  output logic [2:0]    fire_o    // 0 serin, 1 serout, 2 transmit done
);

  logic [15:0] serin_q, serin_d;
  logic [15:0] serout_q, serout_d;
  logic [15:0] xmt_q, xmt_d;
  logic [16:0] xmt_sum;
  logic [15:0] xmt_pre;

  assign fire_o[0] = ctrl_i.tick && (serin_q == 16'd1);
  assign fire_o[1] = ctrl_i.tick && (serout_q == 16'd1);

  // Chain the transmit-done delay off the serial-out expiry, saturating.
  assign xmt_sum   = 17'(xmt_q) + 17'(XMTDONE_DELAY);
  assign xmt_pre   = fire_o[1] ? (xmt_sum[16] ? 16'hFFFF : xmt_sum[15:0]) : xmt_q;
  assign fire_o[2] = ctrl_i.tick && (xmt_pre == 16'd1);

  always_comb begin
    serin_d  = serin_q;
    serout_d = serout_q;
    xmt_d    = xmt_q;
    if (ctrl_i.load_serin) begin
      serin_d = delay_i;
    end
    if (ctrl_i.load_serout) begin
      serout_d = delay_i;
    end
    if (ctrl_i.tick) begin
      if (serin_q != '0) begin
        serin_d = serin_q - 16'd1;
      end
      if (serout_q != '0) begin
        serout_d = serout_q - 16'd1;
      end
      xmt_d = (xmt_pre != '0) ? xmt_pre - 16'd1 : xmt_pre;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serin_q  <= '0;
      serout_q <= '0;
      xmt_q    <= '0;
    end else begin
      serin_q  <= serin_d;
      serout_q <= serout_d;
      xmt_q    <= xmt_d;
    end
  end

endmodule

FILE: src/sti_checker.sv
// Port-level checks of the timer and interrupt register block, bound to the top.
module sti_checker import sti_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [7:0]      read_data_o,
  input logic [IrqW-1:0] irq_raised_o,
  input logic [7:0]      irq_status_now_o,
  input logic            serial_out_valid_o,
  input logic [7:0]      serial_out_byte_o,
  input logic            serial_in_taken_o
);

  // A raised source always shows active (low) in the status after the item.
  a_raised_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((irq_raised_o & irq_status_now_o[IrqW-1:0]) == '0))
    else $error("raised interrupt not active in status");

  // A serial-out write is a write: no read data, no serial-in take.
  a_serout_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && serial_out_valid_o) |->
      (read_data_o == '0 && !serial_in_taken_o && irq_raised_o == '0))
    else $error("serial-out result carries read or interrupt data");

  // Without a serial-out transfer the link byte stays zero.
  a_serout_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !serial_out_valid_o) |-> (serial_out_byte_o == '0))
    else $error("serial-out byte without serial-out transfer");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(read_data_o) && $stable(irq_status_now_o) &&
       $stable(irq_raised_o)))
    else $error("stalled result changed");

endmodule

bind sound_timer_irq_registers sti_checker u_sti_checker (.*);

FILE: tb/tb_sound_timer_irq_registers.sv
// Self-checking testbench of the sound timer and interrupt register block.
`timescale 1ns / 1ps

import sti_pkg::*;

localparam int unsigned ScanlineCycles = 114;
localparam int unsigned SlowBaseCycles = 28;
localparam int unsigned XmtDoneDelay   = 15;

// Commands and offsets that the package leaves without a name.
localparam logic [2:0] CmdSpareFirst = 3'd5;
localparam logic [2:0] CmdSpareLast  = 3'd7;
localparam logic [3:0] OffOddLow     = 4'd1;
localparam logic [3:0] OffSpareA     = 4'd11;
localparam logic [3:0] OffSpareB     = 4'd12;

// Serial delay counters.
localparam int DlySerin  = 0;
localparam int DlySerout = 1;
localparam int DlyXmt    = 2;

typedef struct packed {
  logic [2:0]  command;
  logic [3:0]  reg_offset;
  logic [7:0]  write_data;
  logic [7:0]  external_data;
  logic [7:0]  key_code;
  logic        shift_held;
  logic        key_pressed;
  logic [15:0] delay_value;
} sti_item_t;

typedef struct packed {
  logic [7:0]      read_data;
  logic [IrqW-1:0] irq_raised;
  logic [7:0]      irq_status_now;
  logic            serial_out_valid;
  logic [7:0]      serial_out_byte;
  logic            serial_in_taken;
} sti_resp_t;

// Mirror of the register set: updates its own state per transfer and holds the due responses.
class sti_register_mirror;
  logic [DivW-1:0] div_limit[4];
  logic [DivW-1:0] div_count[4];
  logic [7:0]      freq[4];
  logic [7:0]      audctl;
  logic [7:0]      irq_en;
  logic [7:0]      irq_stat;
  logic [7:0]      skctl;
  logic [15:0]     ser_delay[3];
  sti_resp_t       due_responses[$];
  int unsigned     mismatches;

  function new();
    for (int i = 0; i < 4; i++) begin
      div_limit[i] = '0;
      div_count[i] = '0;
      freq[i] = '0;
    end
    for (int i = 0; i < 3; i++) ser_delay[i] = '0;
    audctl = '0;
    irq_en = '0;
    irq_stat = 8'hFF;
    skctl = '0;
    mismatches = 0;
  endfunction

  // A new limit restarts the channel count; an unchanged one leaves it running.
  function void set_limit(int ch, int unsigned v);
    if (v[DivW-1:0] != div_limit[ch]) begin
      div_limit[ch] = v[DivW-1:0];
      div_count[ch] = '0;
    end
  endfunction

  // Recompute the limits of the channels flagged in chans (bit n = channel n+1).
  function void recompute(logic [3:0] chans);
    int unsigned base;
    int unsigned pair;
    int unsigned v;
    base = audctl[AC_FAST_BASE] ? ScanlineCycles : SlowBaseCycles;
    if (chans[0]) begin
      if (audctl[AC_CH1_FAST]) v = int'(freq[0]) + 4;
      else v = (int'(freq[0]) + 1) * base;
      set_limit(0, v);
    end
    if (chans[1]) begin
      pair = int'(freq[1]) * 256 + int'(freq[0]);
      if (audctl[AC_CH12_JOIN]) begin
        if (audctl[AC_CH1_FAST]) v = pair + 7;
        else v = (pair + 1) * base;
      end else begin
        v = (int'(freq[1]) + 1) * base;
      end
      set_limit(1, v);
    end
    if (chans[2]) begin
      if (audctl[AC_CH3_FAST]) v = int'(freq[2]) + 4;
      else v = (int'(freq[2]) + 1) * base;
      set_limit(2, v);
    end
    if (chans[3]) begin
      pair = int'(freq[3]) * 256 + int'(freq[2]);
      if (audctl[AC_CH34_JOIN]) begin
        if (audctl[AC_CH3_FAST]) v = pair + 7;
        else v = (pair + 1) * base;
      end else begin
        v = (int'(freq[3]) + 1) * base;
      end
      set_limit(3, v);
    end
  endfunction

  // Compare against the limit with the full sum, store it modulo the divider width.
  function bit timer_step(int ch);
    int unsigned sum;
    sum = int'(div_count[ch]) + ScanlineCycles;
    if (sum > int'(div_limit[ch])) begin
      div_count[ch] = '0;
      return 1'b1;
    end
    div_count[ch] = sum[DivW-1:0];
    return 1'b0;
  endfunction

  function bit delay_step(int i);
    if (ser_delay[i] != 16'd0) begin
      ser_delay[i] = ser_delay[i] - 16'd1;
      return ser_delay[i] == 16'd0;
    end
    return 1'b0;
  endfunction

  function sti_resp_t apply_item(sti_item_t it);
    sti_resp_t   r;
    int unsigned xmt;
    r = '0;
    case (it.command)
      CMD_READ: begin
        if (it.reg_offset <= OFF_POT_LAST || it.reg_offset == OFF_RANDOM) begin
          r.read_data = it.external_data;
        end else if (it.reg_offset == OFF_KBCODE) begin
          r.read_data = it.key_code;
        end else if (it.reg_offset == OFF_SERIO) begin
          r.read_data = it.external_data;
          r.serial_in_taken = 1'b1;
        end else if (it.reg_offset == OFF_IRQ) begin
          r.read_data = irq_stat;
        end else if (it.reg_offset == OFF_SKCTL) begin
          r.read_data = 8'hFF;
          if (it.shift_held) r.read_data[SKSTAT_SHIFT] = 1'b0;
          if (it.key_pressed) r.read_data[SKSTAT_KEY] = 1'b0;
        end
      end
      CMD_WRITE: begin
        case (it.reg_offset)
          OFF_FREQ1: begin
            freq[0] = it.write_data;
            recompute(audctl[AC_CH12_JOIN] ? 4'b0011 : 4'b0001);
          end
          OFF_FREQ2: begin
            freq[1] = it.write_data;
            recompute(4'b0010);
          end
          OFF_FREQ3: begin
            freq[2] = it.write_data;
            recompute(audctl[AC_CH34_JOIN] ? 4'b1100 : 4'b0100);
          end
          OFF_FREQ4: begin
            freq[3] = it.write_data;
            recompute(4'b1000);
          end
          OFF_AUDCTL: begin
            audctl = it.write_data;
            recompute(4'b1111);
          end
          OFF_SERIO: begin
            if ((skctl & SKCTL_MODE_MASK) == SKCTL_MODE_SEROUT && freq[2] == FREQ3_SEROUT &&
                freq[3] == 8'h00 && (audctl & AUDCTL_SEROUT) == AUDCTL_SEROUT) begin
              r.serial_out_valid = 1'b1;
              r.serial_out_byte = it.write_data;
            end
          end
          OFF_IRQ: begin
            irq_en = it.write_data;
            irq_stat = irq_stat | ~it.write_data;
          end
          OFF_SKCTL: skctl = it.write_data;
          default: ;
        endcase
      end
      CMD_TICK: begin
        // Serial delays clear status even when disabled; raised only when enabled.
        if (delay_step(DlySerin)) begin
          irq_stat[IRQ_SERIN] = 1'b0;
          r.irq_raised[IRQ_SERIN] = irq_en[IRQ_SERIN];
        end
        if (delay_step(DlySerout)) begin
          irq_stat[IRQ_SEROUT] = 1'b0;
          r.irq_raised[IRQ_SEROUT] = irq_en[IRQ_SEROUT];
          // Chain transmit-done before its own countdown on this tick.
          xmt = int'(ser_delay[DlyXmt]) + XmtDoneDelay;
          ser_delay[DlyXmt] = (xmt > 65535) ? 16'hFFFF : xmt[15:0];
        end
        if (delay_step(DlyXmt)) begin
          irq_stat[IRQ_XMT] = 1'b0;
          r.irq_raised[IRQ_XMT] = irq_en[IRQ_XMT];
        end
        // Timers touch status only when enabled; channel 3 runs but raises nothing.
        if (timer_step(0) && irq_en[IRQ_T1]) begin
          irq_stat[IRQ_T1] = 1'b0;
          r.irq_raised[IRQ_T1] = 1'b1;
        end
        if (timer_step(1) && irq_en[IRQ_T2]) begin
          irq_stat[IRQ_T2] = 1'b0;
          r.irq_raised[IRQ_T2] = 1'b1;
        end
        void'(timer_step(2));
        if (timer_step(3) && irq_en[IRQ_T4]) begin
          irq_stat[IRQ_T4] = 1'b0;
          r.irq_raised[IRQ_T4] = 1'b1;
        end
      end
      CMD_LOAD_SERIN:  ser_delay[DlySerin] = it.delay_value;
      CMD_LOAD_SEROUT: ser_delay[DlySerout] = it.delay_value;
      default: ;
    endcase
    r.irq_status_now = irq_stat;
    return r;
  endfunction

  function void note_transfer(sti_item_t it);
    due_responses.push_back(apply_item(it));
  endfunction

  function void compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function void check_response(sti_resp_t got);
    sti_resp_t want;
    if (due_responses.size() == 0) begin
      $display("%0t: response with none due, actual %0h", $time, got);
      mismatches++;
      return;
    end
    want = due_responses.pop_front();
    compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
    compare_field("irq_raised", 32'(want.irq_raised), 32'(got.irq_raised));
    compare_field("irq_status_now", 32'(want.irq_status_now), 32'(got.irq_status_now));
    compare_field("serial_out_valid", 32'(want.serial_out_valid),
                  32'(got.serial_out_valid));
    compare_field("serial_out_byte", 32'(want.serial_out_byte), 32'(got.serial_out_byte));
    compare_field("serial_in_taken", 32'(want.serial_in_taken), 32'(got.serial_in_taken));
  endfunction

  function int unsigned pending();
    return due_responses.size();
  endfunction
endclass

module tb_sound_timer_irq_registers;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [2:0]      command;
  logic [3:0]      reg_offset;
  logic [7:0]      write_data;
  logic [7:0]      external_data;
  logic [7:0]      key_code;
  logic            shift_held;
  logic            key_pressed;
  logic [15:0]     delay_value;
  logic            out_valid;
  logic            out_ready;
  logic [7:0]      read_data;
  logic [IrqW-1:0] irq_raised;
  logic [7:0]      irq_status_now;
  logic            serial_out_valid;
  logic [7:0]      serial_out_byte;
  logic            serial_in_taken;

  sti_register_mirror mirror;

  sound_timer_irq_registers #(
    .SCANLINE_CYCLES (ScanlineCycles),
    .SLOW_BASE_CYCLES(SlowBaseCycles),
    .XMTDONE_DELAY   (XmtDoneDelay)
  ) i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .command_i         (command),
    .reg_offset_i      (reg_offset),
    .write_data_i      (write_data),
    .external_data_i   (external_data),
    .key_code_i        (key_code),
    .shift_held_i      (shift_held),
    .key_pressed_i     (key_pressed),
    .delay_value_i     (delay_value),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .read_data_o       (read_data),
    .irq_raised_o      (irq_raised),
    .irq_status_now_o  (irq_status_now),
    .serial_out_valid_o(serial_out_valid),
    .serial_out_byte_o (serial_out_byte),
    .serial_in_taken_o (serial_in_taken)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Check every output transfer. Values read at the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mirror.check_response({read_data, irq_raised, irq_status_now,
                             serial_out_valid, serial_out_byte, serial_in_taken});
    end
  end

  // Output side: short random stalls, calm stretches, and long hold-offs that
  // back the block up until it drops in_ready. One long hold-off is forced early.
  initial begin
    int unsigned step;
    bit          calm;
    out_ready = 1'b0;
    step = 0;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      step++;
      if (step % 16 == 0) calm = ($urandom_range(0, 2) == 0);
      if (step == 40 || $urandom_range(0, 99) < 2) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(40, 80)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < 35) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Fill the side fields at random: they only matter to reads.
  function automatic sti_item_t make_item(logic [2:0] cmd, logic [3:0] off, logic [7:0] wd,
                                          logic [15:0] dly);
    sti_item_t it;
    it.command = cmd;
    it.reg_offset = off;
    it.write_data = wd;
    it.external_data = 8'($urandom_range(0, 255));
    it.key_code = 8'($urandom_range(0, 255));
    it.shift_held = 1'($urandom_range(0, 1));
    it.key_pressed = 1'($urandom_range(0, 1));
    it.delay_value = dly;
    return it;
  endfunction

  // Mostly short delays so serial interrupts fire often; some zero, some full range.
  function automatic logic [15:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 12));
    if (r < 85) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic sti_item_t random_item();
    int unsigned r;
    logic [2:0]  cmd;
    logic [3:0]  off;
    logic [7:0]  wd;
    r = $urandom_range(0, 99);
    off = 4'($urandom_range(0, 15));
    wd = 8'($urandom_range(0, 255));
    if (r < 35) begin
      cmd = CMD_TICK;
    end else if (r < 55) begin
      cmd = CMD_READ;
    end else if (r < 85) begin
      cmd = CMD_WRITE;
      // Keep divider limits short most of the time so timers expire.
      if ((off == OFF_FREQ1 || off == OFF_FREQ2 || off == OFF_FREQ3 || off == OFF_FREQ4) &&
          $urandom_range(0, 1) == 1)
        wd = 8'($urandom_range(0, 7));
      if (off == OFF_IRQ && $urandom_range(0, 1) == 1) wd = 8'hFF;
    end else if (r < 92) begin
      cmd = CMD_LOAD_SERIN;
    end else if (r < 98) begin
      cmd = CMD_LOAD_SEROUT;
    end else begin
      cmd = 3'($urandom_range(CmdSpareFirst, CmdSpareLast));
    end
    return make_item(cmd, off, wd, pick_delay());
  endfunction

  function automatic int unsigned idle_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until the transfer, then idle for the given gap.
  task automatic send_item(input sti_item_t it, input int unsigned gap);
    in_valid      <= 1'b1;
    command       <= it.command;
    reg_offset    <= it.reg_offset;
    write_data    <= it.write_data;
    external_data <= it.external_data;
    key_code      <= it.key_code;
    shift_held    <= it.shift_held;
    key_pressed   <= it.key_pressed;
    delay_value   <= it.delay_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.note_transfer(it);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every due response has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  initial begin
    int unsigned n;
    bit          tx_calm;
    logic [7:0]  wd;
    mirror = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = '0;
    reg_offset = '0;
    write_data = '0;
    external_data = '0;
    key_code = '0;
    shift_held = 1'b0;
    key_pressed = 1'b0;
    delay_value = '0;
    tx_calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: the read map including unmapped offsets.
    send_item(make_item(CMD_READ, OFF_FREQ1, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OFF_POT_LAST, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OFF_AUDCTL, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OFF_KBCODE, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OFF_RANDOM, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OffSpareA, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OffSpareB, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OFF_SERIO, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OFF_SKCTL, 8'h00, 16'h0000), 0);
    // Enable everything, then set up the serial-out path and send a byte.
    send_item(make_item(CMD_WRITE, OFF_IRQ, 8'hFF, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OFF_SKCTL, SKCTL_MODE_SEROUT, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OFF_FREQ3, FREQ3_SEROUT, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OFF_FREQ4, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OFF_AUDCTL, AUDCTL_SEROUT, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OFF_SERIO, 8'hA5, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OffOddLow, 8'hFF, 16'h0000), 0);
    // Serial delays expiring on one tick chain into transmit-done.
    send_item(make_item(CMD_LOAD_SERIN, OFF_FREQ1, 8'h00, 16'h0001), 0);
    send_item(make_item(CMD_LOAD_SEROUT, OFF_FREQ1, 8'h00, 16'h0001), 0);
    send_item(make_item(CMD_TICK, OFF_FREQ1, 8'h00, 16'h0000), 0);
    send_item(make_item(CmdSpareLast, OFF_IRQ, 8'hFF, 16'hFFFF), 0);
    send_item(make_item(CMD_LOAD_SERIN, OFF_FREQ1, 8'h00, 16'hFFFF), 0);
    // Fast base, joined pairs and the fast first channel; widest limit on channel 2.
    send_item(make_item(CMD_WRITE, OFF_AUDCTL, 8'h59, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OFF_FREQ2, 8'hFF, 16'h0000), 0);
    send_item(make_item(CMD_TICK, OFF_FREQ1, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_WRITE, OFF_IRQ, 8'h00, 16'h0000), 0);
    send_item(make_item(CMD_READ, OFF_IRQ, 8'h00, 16'h0000), 0);
    drain();

    // Random: mostly single items, some serial-out setup runs with random corruption.
    n = 0;
    while (n < 900) begin
      if (n % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (n != 0 && n % 150 == 0) drain();
      if ($urandom_range(0, 99) < 8) begin
        for (int k = 0; k < 5; k++) begin
          wd = 8'($urandom_range(0, 255));
          case (k)
            0: send_item(make_item(CMD_WRITE, OFF_SKCTL,
                                   (wd & ~SKCTL_MODE_MASK) | SKCTL_MODE_SEROUT, 16'h0000),
                         idle_gap(tx_calm));
            1: send_item(make_item(CMD_WRITE, OFF_FREQ3,
                                   ($urandom_range(0, 4) == 0) ? wd : FREQ3_SEROUT, 16'h0000),
                         idle_gap(tx_calm));
            2: send_item(make_item(CMD_WRITE, OFF_FREQ4,
                                   ($urandom_range(0, 4) == 0) ? wd : 8'h00, 16'h0000),
                         idle_gap(tx_calm));
            3: send_item(make_item(CMD_WRITE, OFF_AUDCTL,
                                   ($urandom_range(0, 4) == 0) ? wd : (wd | AUDCTL_SEROUT),
                                   16'h0000),
                         idle_gap(tx_calm));
            default: send_item(make_item(CMD_WRITE, OFF_SERIO, wd, 16'h0000),
                               idle_gap(tx_calm));
          endcase
        end
        n += 5;
      end else begin
        send_item(random_item(), idle_gap(tx_calm));
        n++;
      end
    end

    // Let the last responses drain, then watch for stray ones.
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sti_pkg.sv
src/sti_divider.sv
src/sti_serial.sv
src/sound_timer_irq_registers.sv
src/sti_checker.sv
tb/tb_sound_timer_irq_registers.sv
